/* hw/rtl/indexed_shifting_list_macros.svh */
// assertion helpers for the indexed shifting list
// all of them sample on clock and are quiet while reset is high
`ifndef INDEXED_SHIFTING_LIST_MACROS_SVH
`define INDEXED_SHIFTING_LIST_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ISL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define ISL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/isl_pkg.sv */
package isl_pkg;

   // fixed field widths of the item ports
   localparam int MODE_W  = 3;
   localparam int IDX_W   = 6;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;
   localparam int STAT_W  = 2;
   localparam int WIDE_W  = 64;

   // request modes
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] item_word;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_word;
      logic [COUNT_W-1:0] entry_count;
      logic               empty_res;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   // what every cell does at the accepting edge
   typedef enum logic [2:0] {
      CK_HOLD,
      CK_APPEND,
      CK_WRITE,
      CK_INSERT,
      CK_REMOVE
   } cell_kind_type;

   typedef struct packed {
      cell_kind_type    kind;
      logic             rd_en;
      logic [IDX_W-1:0] index;
   } cell_op_type;

endpackage

/* hw/rtl/isl_cell.sv */
module isl_cell #(
   parameter int WORD_WIDTH = 32,
   parameter int CNT_W      = 7,
   parameter int POS        = 0
) (
   input  logic                   clock,
   input  isl_pkg::cell_op_type   op,
   input  logic [CNT_W-1:0]       op_count,
   input  logic [WORD_WIDTH-1:0]  load_word,
   input  logic [WORD_WIDTH-1:0]  lower_word,
   input  logic [WORD_WIDTH-1:0]  upper_word,
   output logic [WORD_WIDTH-1:0]  word_q,
   output logic [WORD_WIDTH-1:0]  read_word
);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;
   logic                  hit;
   logic                  above;
   logic [31:0]           idx_ext;
   logic [31:0]           cnt_ext;

   assign idx_ext = 32'(op.index);
   assign cnt_ext = 32'(op_count);
   assign hit     = (idx_ext == 32'(POS));
   assign above   = (idx_ext < 32'(POS));

   // own update: load, take from a neighbor, or keep
   always_comb begin
      word_in = word_ff;
      unique case (op.kind)
         isl_pkg::CK_APPEND: begin
            if (cnt_ext == 32'(POS)) word_in = load_word;
         end
         isl_pkg::CK_WRITE: begin
            if (hit) word_in = load_word;
         end
         isl_pkg::CK_INSERT: begin
            if (hit) word_in = load_word;
            else if (above && (32'(POS) <= cnt_ext)) word_in = lower_word;
         end
         isl_pkg::CK_REMOVE: begin
            if ((hit || above) && (32'(POS) + 32'd1 < cnt_ext)) word_in = upper_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_q    = word_ff;
   // only the addressed cell puts its word on the read tree
   assign read_word = (op.rd_en && hit) ? word_ff : '0;

endmodule

/* hw/rtl/isl_or_tree.sv */
module isl_or_tree #(
   parameter int N = 64,
   parameter int W = 32
) (
   input  logic         clock,
   input  logic [W-1:0] leaf [N],
   output logic [W-1:0] merged
);

   localparam int GROUP = 8;
   localparam int NG    = (N + GROUP - 1) / GROUP;

   logic [W-1:0] group_ff [NG];
   logic [W-1:0] group_in [NG];

   // first level: or of eight neighbors, registered
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            if (g * GROUP + j < N) group_in[g] = group_in[g] | leaf[g * GROUP + j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NG; g++) group_ff[g] <= group_in[g];
   end

   // second level: or across the group registers
   always_comb begin
      merged = '0;
      for (int g = 0; g < NG; g++) merged = merged | group_ff[g];
   end

endmodule

/* hw/rtl/indexed_shifting_list.sv */
// Ordered list of words, one word per cell in a row of CAPACITY cells.
// An item is taken when start is high and busy is low; busy then stays
// high for one cycle, and the result is strobed on rsp_valid from the
// rsp_valid register, which follows the pend register; no new item is
// taken while busy is high. All cell updates (the shift up of an insert,
// the shift down of a remove, or a single load) happen together at the
// accepting edge; while busy is high, the word of a read or remove is
// collected by the registered OR tree. Results cannot be held off, they
// must be taken in the cycle they are strobed.
// Entries are not cleared at reset; only cells below the count are read.
`include "indexed_shifting_list_macros.svh"

module indexed_shifting_list #(
   parameter int CAPACITY   = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  isl_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output isl_pkg::rsp_type rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;
   logic [isl_pkg::STAT_W-1:0]     status_ff;
   logic [isl_pkg::STAT_W-1:0]     status_in;
   logic                           pend_ff;
   logic                           rsp_valid_ff;
   isl_pkg::rsp_type               rsp_ff;
   isl_pkg::rsp_type               rsp_in;
   logic                           accept;
   logic                           in_range;
   logic                           full;
   isl_pkg::cell_op_type           op;
   logic [isl_pkg::WIDE_W-1:0]     wide_in;
   logic [WORD_WIDTH-1:0]          load_word;
   logic [WORD_WIDTH-1:0]          cell_word [CAPACITY];
   logic [WORD_WIDTH-1:0]          cell_read [CAPACITY];
   logic [WORD_WIDTH-1:0]          merged;
   logic [isl_pkg::WIDE_W-1:0]     merged_wide;

   assign accept    = start && !busy;
   assign in_range  = 32'(req_item.index) < 32'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign wide_in   = isl_pkg::WIDE_W'(req_item.item_word);
   assign load_word = wide_in[WORD_WIDTH-1:0];

   // decode the request into a cell command, next count and status
   always_comb begin
      op.kind   = isl_pkg::CK_HOLD;
      op.rd_en  = 1'b0;
      op.index  = req_item.index;
      count_in  = count_ff;
      status_in = isl_pkg::ST_DONE;
      if (accept) begin
         unique case (req_item.mode)
            isl_pkg::MODE_APPEND: begin
               if (full) begin
                  status_in = isl_pkg::ST_FULL;
               end else begin
                  op.kind  = isl_pkg::CK_APPEND;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            isl_pkg::MODE_READ: begin
               if (!in_range) status_in = isl_pkg::ST_RANGE;
               else op.rd_en = 1'b1;
            end
            isl_pkg::MODE_WRITE: begin
               if (!in_range) status_in = isl_pkg::ST_RANGE;
               else op.kind = isl_pkg::CK_WRITE;
            end
            isl_pkg::MODE_INSERT: begin
               if (!in_range) begin
                  status_in = isl_pkg::ST_RANGE;
               end else if (full) begin
                  status_in = isl_pkg::ST_FULL;
               end else begin
                  op.kind  = isl_pkg::CK_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            isl_pkg::MODE_REMOVE: begin
               if (!in_range) begin
                  status_in = isl_pkg::ST_RANGE;
               end else begin
                  op.kind  = isl_pkg::CK_REMOVE;
                  op.rd_en = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: status_in = isl_pkg::ST_DONE;
         endcase
      end
   end

   // row of cells, each wired to its two neighbors
   for (genvar p = 0; p < CAPACITY; p++) begin : g_cell
      logic [WORD_WIDTH-1:0] lower;
      logic [WORD_WIDTH-1:0] upper;
      if (p == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = cell_word[p-1];
      end
      if (p == CAPACITY - 1) begin : g_last
         assign upper = '0;
      end else begin : g_mid_hi
         assign upper = cell_word[p+1];
      end
      isl_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .CNT_W      (CNT_W),
         .POS        (p)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .op_count   (count_ff),
         .load_word  (load_word),
         .lower_word (lower),
         .upper_word (upper),
         .word_q     (cell_word[p]),
         .read_word  (cell_read[p])
      );
   end

   // collect the addressed word over two levels
   isl_or_tree #(
      .N (CAPACITY),
      .W (WORD_WIDTH)
   ) u_tree (
      .clock  (clock),
      .leaf   (cell_read),
      .merged (merged)
   );

   assign merged_wide = isl_pkg::WIDE_W'(merged);

   // result assembly while busy is high
   always_comb begin
      rsp_in.read_word   = merged_wide[isl_pkg::DATA_W-1:0];
      rsp_in.entry_count = isl_pkg::COUNT_W'(count_ff);
      rsp_in.empty_res   = (count_ff == '0);
      rsp_in.status      = status_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= accept;
         rsp_valid_ff <= pend_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) status_ff <= status_in;
      if (pend_ff) rsp_ff <= rsp_in;
   end

   assign busy      = pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ISL_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_valid, "accepted item did not raise busy")
   `ISL_ASSERT_NEXT(a_busy_result, busy, rsp_valid && !busy, "result not strobed after busy")
   `ISL_ASSERT_SAME(a_count_cap, 1'b1, 32'(count_ff) <= 32'(CAPACITY), "count above capacity")
   `ISL_ASSERT_SAME(a_empty_flag, rsp_valid, rsp_item.empty_res == (rsp_item.entry_count == '0), "empty flag disagrees with count")
   `ISL_ASSERT_SAME(a_full_count, rsp_valid && (rsp_item.status == isl_pkg::ST_FULL), 32'(rsp_item.entry_count) == (32'(CAPACITY) & 32'h7f), "full reported below capacity")

endmodule
